// ===== design/sacml_pkg.sv =====
package sacml_pkg;

    // cache geometry
    localparam int SET_COUNT  = 256;
    localparam int WAY_COUNT  = 8;
    localparam int LINE_COUNT = SET_COUNT * WAY_COUNT;

    localparam int SET_W   = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int WAY_W   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int WCNT_W  = $clog2(WAY_COUNT + 1);
    localparam int LINE_W  = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    // largest s with 2^s <= SET_COUNT
    localparam int IDX_MAX = $clog2(SET_COUNT + 1) - 1;

    // field widths
    localparam int ADDR_W      = 64;
    localparam int TAG_W       = 64;
    localparam int CNT_W       = 32;
    localparam int WAY_OUT_W   = 3;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_FIELD_W = 2 + WAY_OUT_W + 3 * CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_INDEX_BITS    = 2'd0,
        CFG_BLOCK_OFFSET_BITS = 2'd1,
        CFG_WAYS_IN_USE       = 2'd2
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_SCAN,
        ST_DONE
    } state_t;

    // saturating increment of a running total
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// ===== design/set_assoc_cache_mru_lookup_core.sv =====
// channel   dir  signals                         accepted when
// s_axis    in   tvalid tready tdata[63:0]       s_axis_tvalid && s_axis_tready
// m_axis    out  tvalid tready tdata[103:0]      m_axis_tvalid && m_axis_tready
// cfg       in   cfg_we cfg_addr[1:0] cfg_wdata  cfg_we
//
// one request passes these steps, ways being ways_in_use clamped to 1..8:
// accept, address split, one way per cycle on a shared 64-bit tag comparator, result load;
// a hit in way w ends the scan early, before the remaining ways
// after rst_n a clearing pass over all 256 sets zeroes the line valid bits, s_axis_tready low
// a stalled result is held in the output register while one more request is processed
module set_assoc_cache_mru_lookup_core
    import sacml_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [ADDR_W-1:0]      s_axis_tdata,   // [63:0] address
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] hit, [1] evicted, [4:2] way_used, [36:5] hits_total,
    // [68:37] misses_total, [100:69] evictions_total, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] idx_bits_reg;
    logic [CFG_W-1:0] off_bits_reg;
    logic [CFG_W-1:0] ways_cfg_reg;

    logic [ADDR_W-1:0] shift_reg;
    logic [SET_W-1:0]  set_reg;
    logic [TAG_W-1:0]  tag_reg;

    logic [WCNT_W-1:0] scan_way_reg;
    logic              cmp_valid_reg;
    logic [WAY_W-1:0]  cmp_way_reg;

    logic [SET_W-1:0]  clr_reg;

    logic [TAG_W-1:0]  tag_mem [LINE_COUNT];
    logic [TAG_W-1:0]  tag_rd_reg;
    logic [WAY_W-1:0]  recent_mem [SET_COUNT];
    logic [WAY_W-1:0]  recent_rd_reg;
    logic [WAY_COUNT-1:0] valid_mem [SET_COUNT];
    logic [WAY_COUNT-1:0] valid_rd_reg;

    logic [CNT_W-1:0] hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;
    logic             hit_res_reg, evict_res_reg;
    logic [WAY_W-1:0] way_res_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    logic [CFG_W-1:0]     eff_idx;
    logic [WCNT_W-1:0]    eff_ways;
    logic [WAY_COUNT-1:0] en_mask;
    logic [SET_W-1:0]     set_mask;
    logic [WAY_COUNT-1:0] row;
    logic [WAY_COUNT-1:0] fill_row;
    logic [WAY_COUNT-1:0] free_vec;
    logic                 free_found;
    logic [WAY_W-1:0]     free_way;
    logic [WAY_W-1:0]     recent_eff;
    logic [WAY_W-1:0]     chosen;
    logic                 cmp_match;
    logic                 scan_end;
    logic                 finish;
    logic                 evict_now;
    logic [LINE_W-1:0]    rd_line;
    logic [LINE_W-1:0]    wr_line;

    logic accept;
    logic clear_go;
    logic split_go;
    logic scan_issue;
    logic line_commit;
    logic out_load;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_bits_reg <= CFG_W'(4);
            off_bits_reg <= CFG_W'(4);
            ways_cfg_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_SET_INDEX_BITS:    idx_bits_reg <= cfg_wdata;
                CFG_BLOCK_OFFSET_BITS: off_bits_reg <= cfg_wdata;
                CFG_WAYS_IN_USE:       ways_cfg_reg <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    // effective index width, way count and enabled ways
    always_comb
    begin
        eff_idx = (int'(idx_bits_reg) > IDX_MAX) ? CFG_W'(IDX_MAX) : idx_bits_reg;
        if (ways_cfg_reg == '0)
            eff_ways = WCNT_W'(1);
        else if (int'(ways_cfg_reg) > WAY_COUNT)
            eff_ways = WCNT_W'(WAY_COUNT);
        else
            eff_ways = WCNT_W'(ways_cfg_reg);
        for (int i = 0; i < WAY_COUNT; i++)
            en_mask[i] = (WCNT_W'(i) < eff_ways);
        set_mask = ~({SET_W{1'b1}} << eff_idx);
    end

    // way scan and replacement choice
    always_comb
    begin
        row        = valid_rd_reg;
        cmp_match  = cmp_valid_reg && row[cmp_way_reg] && (tag_rd_reg == tag_reg);
        scan_end   = (scan_way_reg == eff_ways);
        finish     = cmp_match || scan_end;
        free_vec   = ~row & en_mask;
        free_found = |free_vec;
        free_way   = '0;
        for (int i = WAY_COUNT - 1; i >= 0; i--)
        begin
            if (free_vec[i])
                free_way = WAY_W'(i);
        end
        // stale recent way after shrinking falls back to the highest enabled way
        if (WCNT_W'(recent_rd_reg) >= eff_ways)
            recent_eff = WAY_W'(eff_ways - 1'b1);
        else
            recent_eff = recent_rd_reg;
        evict_now = !cmp_match && !free_found;
        if (cmp_match)
            chosen = cmp_way_reg;
        else if (free_found)
            chosen = free_way;
        else
            chosen = recent_eff;
        fill_row = row | (WAY_COUNT'(1) << chosen);
        rd_line = LINE_W'(int'(set_reg) * WAY_COUNT + int'(scan_way_reg[WAY_W-1:0]));
        wr_line = LINE_W'(int'(set_reg) * WAY_COUNT + int'(chosen));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == SET_W'(SET_COUNT - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_axis_tvalid) state_next = ST_SPLIT;
            ST_SPLIT: state_next = ST_SCAN;
            ST_SCAN:  if (finish) state_next = ST_DONE;
            ST_DONE:  if (!m_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        clear_go      = 1'b0;
        split_go      = 1'b0;
        scan_issue    = 1'b0;
        line_commit   = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_CLEAR: clear_go = 1'b1;
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_SPLIT: split_go = 1'b1;
            ST_SCAN:
            begin
                scan_issue  = !finish;
                line_commit = finish;
            end
            ST_DONE:  out_load = !m_valid_reg || m_axis_tready;
            default:  ;
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // clearing pass over the valid bit rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (clear_go)
            clr_reg <= clr_reg + 1'b1;
    end

    // address split: offset shift on accept, then set and tag
    always_ff @(posedge clk)
    begin
        if (accept)
            shift_reg <= s_axis_tdata >> off_bits_reg;
        if (split_go)
        begin
            set_reg <= shift_reg[SET_W-1:0] & set_mask;
            tag_reg <= shift_reg >> eff_idx;
        end
    end

    // scan counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_way_reg  <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else if (split_go)
        begin
            scan_way_reg  <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else if (scan_issue)
        begin
            scan_way_reg  <= scan_way_reg + 1'b1;
            cmp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_issue)
            cmp_way_reg <= scan_way_reg[WAY_W-1:0];
    end

    // tag memory: one read and one write port
    always_ff @(posedge clk)
    begin
        if (line_commit && !cmp_match)
            tag_mem[wr_line] <= tag_reg;
        tag_rd_reg <= tag_mem[rd_line];
    end

    // most recent way per set
    always_ff @(posedge clk)
    begin
        if (line_commit)
            recent_mem[set_reg] <= chosen;
        recent_rd_reg <= recent_mem[set_reg];
    end

    // line valid bits, one row per set
    always_ff @(posedge clk)
    begin
        if (clear_go)
            valid_mem[clr_reg] <= '0;
        else if (line_commit && !cmp_match)
            valid_mem[set_reg] <= fill_row;
        valid_rd_reg <= valid_mem[set_reg];
    end

    // running totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end
        else if (line_commit)
        begin
            if (cmp_match)
                hit_cnt_reg <= sat_inc(hit_cnt_reg);
            else
            begin
                miss_cnt_reg <= sat_inc(miss_cnt_reg);
                if (evict_now)
                    evict_cnt_reg <= sat_inc(evict_cnt_reg);
            end
        end
    end

    // per-request result
    always_ff @(posedge clk)
    begin
        if (line_commit)
        begin
            hit_res_reg   <= cmp_match;
            evict_res_reg <= evict_now;
            way_res_reg   <= chosen;
        end
    end

    // output register
    always_comb
    begin
        if (out_load)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_data_reg <= OUT_TDATA_W'({evict_cnt_reg, miss_cnt_reg, hit_cnt_reg,
                                        WAY_OUT_W'(way_res_reg), evict_res_reg,
                                        hit_res_reg});
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
